[src/tcw_pkg.sv]
// Shared types, codes and constants for the text console writer.
package tcw_pkg;

    localparam int DEF_COLS = 80;
    localparam int DEF_ROWS = 25;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] ATTR_BODY    = 8'h0F;
    localparam logic [7:0] ATTR_TITLE   = 8'h1F;

    localparam logic [15:0] BLANK_BODY  = {ATTR_BODY, CH_SPACE};
    localparam logic [15:0] BLANK_TITLE = {ATTR_TITLE, CH_SPACE};

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  ch;
        logic [7:0]  color;
        logic [10:0] cell_index;
    } t_in;

    typedef struct packed {
        logic [6:0]  pos_col;
        logic [4:0]  pos_row;
        logic        scrolled;
        logic [15:0] cell_value;
    } t_out;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_BLANK,
        ST_DONE
    } t_state;

endpackage

[src/text_console_writer_unit.sv]
// Text console writer: screen store, cursor, scroll and clear sequencer.
//
// Input channel i_in (valid/stall) takes one item: put character, clear
// screen or read one cell. Output channel o_out gives one result per item:
// cursor after the item, a scroll flag and the read cell value.
// One item is worked at a time (a read passes through ST_READ as well);
// o_in_stall is high from acceptance until the result is loaded into the
// output register. The output register lets the next item be accepted
// while a result waits to be taken.
// A step that passes the bottom row adds a copy of rows 2 to ROWS-1 up by
// one row plus the blanking of the last row; clear rewrites all COLS*ROWS
// cells. All of these walk the single write and single read port of the
// screen memory, one cell per cycle. The row copy overlaps the read of one
// cell with the write of the cell before it.
// After reset the block runs a clearing pass over all cells with o_in_stall
// high; the cursor starts at column 0 of row 1.
// While the receiver stalls, the result holds in the output register; a
// further item may be accepted and its result waits in the sequencer.
module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int COLS = DEF_COLS,
    parameter int ROWS = DEF_ROWS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    localparam int CELLS  = COLS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int PTR_W  = $clog2(CELLS + 1);
    localparam int COL_W  = $clog2(COLS);
    localparam int ROW_W  = $clog2(ROWS);

    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLS);
    localparam logic [ADDR_W-1:0] SHIFT_A   = ADDR_W'(COLS + 1);
    localparam logic [COL_W:0]    COLS_X    = (COL_W + 1)'(COLS);
    localparam logic [ROW_W:0]    ROWS_X    = (ROW_W + 1)'(ROWS);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [ROW_W-1:0]  ROW_HOME  = ROW_W'(1);
    localparam logic [PTR_W-1:0]  PTR_END   = PTR_W'(CELLS);
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(CELLS - 1);
    localparam logic [PTR_W-1:0]  PTR_COPY  = PTR_W'(2 * COLS);
    localparam logic [PTR_W-1:0]  PTR_BOT   = PTR_W'(CELLS - COLS);
    localparam logic [PTR_W-1:0]  PTR_TITLE = PTR_W'(COLS);

    t_state           r_state, n_state;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [PTR_W-1:0] r_ptr, n_ptr;
    logic             r_rd_ok, n_rd_ok;
    logic             r_clr_reply, n_clr_reply;
    logic             r_scrolled, n_scrolled;
    logic [15:0]      r_value, n_value;
    logic             r_out_valid, n_out_valid;
    t_out             r_out, n_out;

    logic [15:0]       r_mem [CELLS];
    logic [15:0]       r_rdata;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    logic              accept;
    logic              out_free;
    logic              wrap;
    logic              idx_ok;
    logic [ADDR_W-1:0] cur_addr;
    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    row_inc;
    logic [ROW_W:0]    row_nx;

    assign accept     = i_in_valid && (r_state == ST_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign cur_addr = ADDR_W'(r_row) * COLS_A + ADDR_W'(r_col);
    assign col_inc  = {1'b0, r_col} + 1'b1;
    assign row_inc  = {1'b0, r_row} + 1'b1;
    assign idx_ok   = 32'(i_in.cell_index) < CELLS;

    // cursor step of a put item
    always_comb begin
        n_col  = r_col;
        row_nx = {1'b0, r_row};
        if (i_in.ch == CH_NEWLINE) begin
            n_col  = '0;
            row_nx = row_inc;
        end else if (i_in.ch == CH_BACKSPACE) begin
            if (r_col != '0) begin
                n_col = r_col - 1'b1;
            end
        end else if (col_inc == COLS_X) begin
            n_col  = '0;
            row_nx = row_inc;
        end else begin
            n_col = col_inc[COL_W-1:0];
        end
        wrap = (row_nx == ROWS_X);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_ptr == PTR_LAST) begin
                    n_state = r_clr_reply ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_in.op)
                        OP_PUT:   n_state = wrap ? ST_SCROLL : ST_DONE;
                        OP_CLEAR: n_state = ST_CLEAR;
                        OP_READ:  n_state = ST_READ;
                        default:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_READ: n_state = ST_DONE;
            ST_SCROLL: begin
                if (r_ptr == PTR_END) begin
                    n_state = ST_BLANK;
                end
            end
            ST_BLANK: begin
                if (r_ptr == PTR_LAST) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_ptr       = r_ptr;
        n_rd_ok     = 1'b0;
        n_clr_reply = r_clr_reply;
        n_scrolled  = r_scrolled;
        n_value     = r_value;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = BLANK_BODY;
        mem_raddr   = '0;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr[ADDR_W-1:0];
                mem_wdata = (r_ptr < PTR_TITLE) ? BLANK_TITLE : BLANK_BODY;
                n_ptr     = r_ptr + 1'b1;
            end
            ST_IDLE: begin
                if (accept) begin
                    n_scrolled = 1'b0;
                    n_value    = '0;
                    unique case (i_in.op)
                        OP_PUT: begin
                            if (i_in.ch == CH_BACKSPACE) begin
                                mem_we    = (r_col != '0);
                                mem_waddr = cur_addr - 1'b1;
                                mem_wdata = BLANK_BODY;
                            end else if (i_in.ch != CH_NEWLINE) begin
                                mem_we    = 1'b1;
                                mem_waddr = cur_addr;
                                mem_wdata = {i_in.color, i_in.ch};
                            end
                            n_scrolled = wrap;
                            n_ptr      = PTR_COPY;
                        end
                        OP_CLEAR: begin
                            n_ptr       = '0;
                            n_clr_reply = 1'b1;
                        end
                        OP_READ: begin
                            mem_raddr = idx_ok ? ADDR_W'(i_in.cell_index) : '0;
                            n_rd_ok   = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                n_value = r_rd_ok ? r_rdata : '0;
            end
            ST_SCROLL: begin
                if (r_ptr != PTR_END) begin
                    mem_raddr = r_ptr[ADDR_W-1:0];
                    n_ptr     = r_ptr + 1'b1;
                    n_rd_ok   = 1'b1;
                end else begin
                    n_ptr = PTR_BOT;
                end
                if (r_rd_ok) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_ptr[ADDR_W-1:0] - SHIFT_A;
                    mem_wdata = r_rdata;
                end
            end
            ST_BLANK: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr[ADDR_W-1:0];
                mem_wdata = BLANK_BODY;
                n_ptr     = r_ptr + 1'b1;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.pos_col    = 7'(r_col);
                    n_out.pos_row    = 5'(r_row);
                    n_out.scrolled   = r_scrolled;
                    n_out.cell_value = r_value;
                end
            end
            default: ;
        endcase
        // read op: remember whether the index was in range
        if (accept && (i_in.op == OP_READ)) begin
            n_rd_ok = idx_ok;
        end
    end

    // cursor register update
    logic [COL_W-1:0] cur_col_nx;
    logic [ROW_W-1:0] cur_row_nx;

    always_comb begin
        cur_col_nx = r_col;
        cur_row_nx = r_row;
        if (accept) begin
            if (i_in.op == OP_PUT) begin
                cur_col_nx = n_col;
                cur_row_nx = wrap ? ROW_LAST : row_nx[ROW_W-1:0];
            end else if (i_in.op == OP_CLEAR) begin
                cur_col_nx = '0;
                cur_row_nx = ROW_HOME;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_col       <= '0;
            r_row       <= ROW_HOME;
            r_ptr       <= '0;
            r_rd_ok     <= 1'b0;
            r_clr_reply <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= cur_col_nx;
            r_row       <= cur_row_nx;
            r_ptr       <= n_ptr;
            r_rd_ok     <= n_rd_ok;
            r_clr_reply <= n_clr_reply;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scrolled <= n_scrolled;
        r_value    <= n_value;
        r_out      <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

`ifndef SYNTHESIS
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_col) < COLS) && (r_row != '0) && (32'(r_row) < ROWS))
        else $error("cursor out of range");

    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (32'(mem_waddr) < CELLS))
        else $error("memory write beyond screen");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("input ready right after an item");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result without finished item");

    a_copy_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCROLL) && r_rd_ok |-> (r_ptr > PTR_COPY))
        else $error("row copy write before its read");
`endif

endmodule
